// ----- rtl/mbrtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared constants, types and the CRC-16/MODBUS byte step for the RTU slave.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

   localparam int NUM_REGS      = 64;
   localparam int MAX_READ_REGS = 29;
   localparam int REG_AW        = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int CNT_W         = $clog2(MAX_READ_REGS + 1);

   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'd4;
   localparam logic [7:0]  MIN_FRAME_BYTES   = 8'd8;
   localparam logic [7:0]  HEADER_BYTES      = 8'd6;
   localparam logic [7:0]  COUNT_MAX         = 8'd255;

   typedef enum logic [1:0] {
      DEC_DROP,
      DEC_READ,
      DEC_WRITE
   } dec_type;

   typedef enum logic [2:0] {
      SRC_HDR,
      SRC_LEN,
      SRC_REG_HI,
      SRC_REG_LO,
      SRC_CRC_LO,
      SRC_CRC_HI
   } src_type;

   typedef struct packed {
      logic       take_byte;
      logic       clear_frame;
      logic       start_resp;
      logic       write_reg;
      logic       load;
      src_type    src;
      logic [2:0] hdr_idx;
      logic       last;
      logic       next_reg;
   } ctrl_cmd_type;

   typedef struct packed {
      dec_type          decision;
      logic [CNT_W-1:0] read_count;
      logic             slot_free;
   } dp_status_type;

   // One byte through the reflected CRC-16/MODBUS register.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/modbus_rtu_slave_register_handler.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_handler
// Modbus RTU slave: frame check, read/write holding registers, reply bytes.
// ----------------------------------------------------------------------------
// Request channel (req_): one received byte per word, req_frame_end set on the
// last byte of a frame. A word is taken when req_valid is high and req_stall
// low. Bytes inside a frame are taken one per cycle; the word with
// req_frame_end is followed by state S_CHECK, which judges the frame.
// Response channel (rsp_): one reply byte per word, rsp_tx_last on the final
// CRC byte. Bytes held back by rsp_stall stay in the output register; the
// sequencer waits for the slot and never drops or repeats a byte.
// The first reply byte is loaded into the output register in state S_HDR,
// after S_CHECK (and S_WRITE for a write, which first updates the register
// file). Header and CRC bytes follow one per cycle while the slot is free;
// each read register steps S_FETCH, S_RD_HI, S_RD_LO (single registered port).
// Requests are stalled while a reply is being built; the next frame is taken
// as soon as the final reply byte sits in the output register.
// csr_: a write of csr_write_data sets the station address (reset value 4).
// Reset (synchronous, active high) clears the frame state, returns the
// address to 4 and marks every holding register as zero.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_handler (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last
);
   import mbrtu_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer: owns all timing, issues one command word per cycle
   mbrtu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_frame_end),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath: frame store, CRC units, register file and output register
   mbrtu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_rx_byte      (req_rx_byte),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_tx_last      (rsp_tx_last)
   );

endmodule

// ----- rtl/mbrtu_datapath.sv -----
// ----------------------------------------------------------------------------
// mbrtu_datapath
// Frame collection, CRC check, register file and the response word register.
// ----------------------------------------------------------------------------
module mbrtu_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [7:0]               csr_write_data,
   input  logic [7:0]               req_rx_byte,
   input  logic                     rsp_stall,
   input  mbrtu_pkg::ctrl_cmd_type  cmd,
   output mbrtu_pkg::dp_status_type status,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_tx_byte,
   output logic                     rsp_tx_last
);
   import mbrtu_pkg::*;

   logic [7:0]  slave_addr_ff;
   logic [7:0]  count_ff;
   logic [15:0] crc_ff;
   logic [7:0]  delay_ff [2];
   logic [7:0]  header_ff [6];
   logic [15:0] resp_crc_ff;
   logic [15:0] resp_crc_in;
   logic [REG_AW-1:0] ptr_ff;

   logic [15:0] mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [15:0] mem_q_ff;
   logic        valid_q_ff;
   logic [15:0] reg_word;

   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;

   logic [15:0] start_addr;
   logic [15:0] value;
   logic [16:0] end_addr;
   logic        crc_ok;
   logic        addr_ok;
   logic [7:0]  hdr_sel;
   logic [7:0]  load_byte;

   assign start_addr = {header_ff[2], header_ff[3]};
   assign value      = {header_ff[4], header_ff[5]};
   assign end_addr   = {1'b0, start_addr} + {1'b0, value};
   assign crc_ok     = (count_ff >= MIN_FRAME_BYTES) && ({delay_ff[1], delay_ff[0]} == crc_ff);
   assign addr_ok    = (header_ff[0] != 8'h00) && (header_ff[0] == slave_addr_ff);

   always_comb begin
      status.decision   = DEC_DROP;
      status.read_count = value[CNT_W-1:0];
      status.slot_free  = !out_valid_ff || !rsp_stall;
      if (crc_ok && addr_ok) begin
         if (header_ff[1] == FUNC_READ_HOLDING) begin
            if ((value != 16'd0) && (value <= 16'(MAX_READ_REGS))
                && (end_addr <= 17'(NUM_REGS))) begin
               status.decision = DEC_READ;
            end
         end else if (header_ff[1] == FUNC_WRITE_SINGLE) begin
            if ({1'b0, start_addr} < 17'(NUM_REGS)) begin
               status.decision = DEC_WRITE;
            end
         end
      end
   end

   always_comb begin
      unique case (cmd.hdr_idx)
         3'd0:    hdr_sel = header_ff[0];
         3'd1:    hdr_sel = header_ff[1];
         3'd2:    hdr_sel = header_ff[2];
         3'd3:    hdr_sel = header_ff[3];
         3'd4:    hdr_sel = header_ff[4];
         3'd5:    hdr_sel = header_ff[5];
         default: hdr_sel = 8'h00;
      endcase
   end

   assign reg_word = valid_q_ff ? mem_q_ff : 16'h0000;

   always_comb begin
      unique case (cmd.src)
         SRC_HDR:    load_byte = hdr_sel;
         SRC_LEN:    load_byte = {header_ff[5][6:0], 1'b0};
         SRC_REG_HI: load_byte = reg_word[15:8];
         SRC_REG_LO: load_byte = reg_word[7:0];
         SRC_CRC_LO: load_byte = resp_crc_ff[7:0];
         SRC_CRC_HI: load_byte = resp_crc_ff[15:8];
         default:    load_byte = 8'h00;
      endcase
   end

   always_comb begin
      resp_crc_in = resp_crc_ff;
      if (cmd.start_resp) begin
         resp_crc_in = CRC_INIT;
      end else if (cmd.load && (cmd.src != SRC_CRC_LO) && (cmd.src != SRC_CRC_HI)) begin
         resp_crc_in = crc_feed(resp_crc_ff, load_byte);
      end
   end

   // Station address register
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDR_RESET;
      end else if (csr_write_enable) begin
         slave_addr_ff <= csr_write_data;
      end
   end

   // Frame collection: hold back the two newest bytes from the CRC
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 8'd0;
         crc_ff      <= CRC_INIT;
         delay_ff[0] <= 8'h00;
         delay_ff[1] <= 8'h00;
         for (int i = 0; i < 6; i++) begin
            header_ff[i] <= 8'h00;
         end
      end else if (cmd.clear_frame) begin
         count_ff    <= 8'd0;
         crc_ff      <= CRC_INIT;
         delay_ff[0] <= 8'h00;
         delay_ff[1] <= 8'h00;
      end else if (cmd.take_byte) begin
         if (count_ff >= 8'd2) begin
            crc_ff <= crc_feed(crc_ff, delay_ff[0]);
         end
         delay_ff[0] <= delay_ff[1];
         delay_ff[1] <= req_rx_byte;
         if (count_ff < HEADER_BYTES) begin
            header_ff[count_ff[2:0]] <= req_rx_byte;
         end
         if (count_ff != COUNT_MAX) begin
            count_ff <= count_ff + 8'd1;
         end
      end
   end

   // Response CRC and register pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         resp_crc_ff <= CRC_INIT;
         ptr_ff      <= '0;
      end else begin
         resp_crc_ff <= resp_crc_in;
         if (cmd.start_resp) begin
            ptr_ff <= start_addr[REG_AW-1:0];
         end else if (cmd.next_reg) begin
            ptr_ff <= ptr_ff + REG_AW'(1);
         end
      end
   end

   // Register file: valid bits stand in for the all-zero reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_reg) begin
         valid_ff[start_addr[REG_AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_reg) begin
         mem[start_addr[REG_AW-1:0]] <= value;
      end
      mem_q_ff   <= mem[ptr_ff];
      valid_q_ff <= valid_ff[ptr_ff];
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_byte_ff <= load_byte;
         out_last_ff <= cmd.last;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_tx_byte = out_byte_ff;
   assign rsp_tx_last = out_last_ff;

endmodule

// ----- rtl/mbrtu_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbrtu_ctrl
// Sequencer: accepts request words, judges the frame, steps out the response.
// ----------------------------------------------------------------------------
module mbrtu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_frame_end,
   output logic                     req_stall,
   input  mbrtu_pkg::dp_status_type status,
   output mbrtu_pkg::ctrl_cmd_type  cmd
);
   import mbrtu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_WRITE,
      S_HDR,
      S_LEN,
      S_FETCH,
      S_RD_HI,
      S_RD_LO,
      S_CRC_LO,
      S_CRC_HI
   } state_type;

   state_type        state_ff;
   logic             is_read_ff;
   logic [2:0]       idx_ff;
   logic [CNT_W-1:0] remain_ff;
   logic             accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.src         = SRC_HDR;
      cmd.hdr_idx     = idx_ff;
      cmd.take_byte   = accept;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_CHECK: begin
            cmd.clear_frame = 1'b1;
            cmd.start_resp  = (status.decision != DEC_DROP);
         end
         S_WRITE: begin
            cmd.write_reg = 1'b1;
         end
         S_HDR: begin
            cmd.load = status.slot_free;
         end
         S_LEN: begin
            cmd.load = status.slot_free;
            cmd.src  = SRC_LEN;
         end
         S_FETCH: begin
         end
         S_RD_HI: begin
            cmd.load = status.slot_free;
            cmd.src  = SRC_REG_HI;
         end
         S_RD_LO: begin
            cmd.load     = status.slot_free;
            cmd.src      = SRC_REG_LO;
            cmd.next_reg = status.slot_free;
         end
         S_CRC_LO: begin
            cmd.load = status.slot_free;
            cmd.src  = SRC_CRC_LO;
         end
         S_CRC_HI: begin
            cmd.load = status.slot_free;
            cmd.src  = SRC_CRC_HI;
            cmd.last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         is_read_ff <= 1'b0;
         idx_ff     <= 3'd0;
         remain_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_frame_end) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               idx_ff     <= 3'd0;
               remain_ff  <= status.read_count;
               is_read_ff <= (status.decision == DEC_READ);
               unique case (status.decision)
                  DEC_READ:  state_ff <= S_HDR;
                  DEC_WRITE: state_ff <= S_WRITE;
                  default:   state_ff <= S_IDLE;
               endcase
            end
            S_WRITE: begin
               state_ff <= S_HDR;
            end
            S_HDR: begin
               if (status.slot_free) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (is_read_ff && (idx_ff == 3'd1)) begin
                     state_ff <= S_LEN;
                  end else if (!is_read_ff && (idx_ff == 3'd5)) begin
                     state_ff <= S_CRC_LO;
                  end
               end
            end
            S_LEN: begin
               if (status.slot_free) begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               state_ff <= S_RD_HI;
            end
            S_RD_HI: begin
               if (status.slot_free) begin
                  state_ff <= S_RD_LO;
               end
            end
            S_RD_LO: begin
               if (status.slot_free) begin
                  remain_ff <= remain_ff - CNT_W'(1);
                  if (remain_ff == CNT_W'(1)) begin
                     state_ff <= S_CRC_LO;
                  end else begin
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_CRC_LO: begin
               if (status.slot_free) begin
                  state_ff <= S_CRC_HI;
               end
            end
            S_CRC_HI: begin
               if (status.slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
